// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the base64url id decoder.
// Used by files that check their own logic; SYNTH removes the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// expr must hold at every clock edge out of reset
`define B64_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: assertion failed");
// cons must hold in the cycle after ante
`define B64_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define B64_ASSERT(lbl, expr)
`define B64_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/b64id_pkg.sv =====
// Package for the base64url id decoder: item types, constants and the
// alphabet map. No dependencies.
`default_nettype none

package b64id_pkg;

    localparam logic [3:0] TOKEN_LEN    = 4'd11;
    localparam logic [3:0] LAST_POS     = 4'd10;
    localparam logic [7:0] INVALID_CODE = 8'h80;
    localparam logic [7:0] BODY_MASK    = 8'hC0;
    localparam logic [7:0] TAIL_MASK    = 8'hC3;
    localparam logic [7:0] CODE_DASH    = 8'd62;
    localparam logic [7:0] CODE_USCORE  = 8'd63;
    localparam logic [7:0] CODE_DIGIT0  = 8'd52;
    localparam logic [7:0] CODE_LOWER_A = 8'd26;

    typedef struct packed {
        logic [7:0] symbol;
        logic       is_final;
    } item_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] ident;
    } result_t;

    // ASCII to 6-bit value, INVALID_CODE outside the alphabet
    function automatic logic [7:0] map_symbol(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h41 && c <= 8'h5A)
            v = c - 8'h41;
        else if (c >= 8'h61 && c <= 8'h7A)
            v = c - 8'h61 + CODE_LOWER_A;
        else if (c >= 8'h30 && c <= 8'h39)
            v = c - 8'h30 + CODE_DIGIT0;
        else if (c == 8'h2D)
            v = CODE_DASH;
        else if (c == 8'h5F)
            v = CODE_USCORE;
        else
            v = INVALID_CODE;
        return v;
    endfunction

    // bit offset of a body character, MSB first
    function automatic logic [5:0] shift_amt(input logic [3:0] pos);
        logic [5:0] sh;
        unique case (pos)
            4'd0:    sh = 6'd58;
            4'd1:    sh = 6'd52;
            4'd2:    sh = 6'd46;
            4'd3:    sh = 6'd40;
            4'd4:    sh = 6'd34;
            4'd5:    sh = 6'd28;
            4'd6:    sh = 6'd22;
            4'd7:    sh = 6'd16;
            4'd8:    sh = 6'd10;
            4'd9:    sh = 6'd4;
            default: sh = 6'd0;
        endcase
        return sh;
    endfunction

endpackage

`default_nettype wire

// ===== design/b64id_core.sv =====
// Decode stage: token state, identifier assembly and the result register.
// Depends on b64id_pkg.
`default_nettype none

module b64id_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              in_valid,
    input  wire b64id_pkg::item_t  in_item,
    output logic                   out_valid,
    output b64id_pkg::result_t     out_result
);

    logic [3:0]  position_reg, position_next;
    logic [63:0] accum_reg, accum_next;
    logic        bad_reg, bad_next;
    logic [63:0] stored_reg, stored_next;
    logic        out_valid_reg;
    b64id_pkg::result_t result_reg, result_next;

    logic [7:0]  code;
    logic        bad_now;
    logic [63:0] accum_upd;
    logic        token_ok;
    logic        take;

    assign take = advance && in_valid;
    assign code = b64id_pkg::map_symbol(in_item.symbol);

    always_comb
    begin
        bad_now   = 1'b0;
        accum_upd = accum_reg;
        if (position_reg < b64id_pkg::LAST_POS)
        begin
            if ((code & b64id_pkg::BODY_MASK) != 8'd0)
                bad_now = 1'b1;
            else
                accum_upd = accum_reg
                    | (64'(code[5:0]) << b64id_pkg::shift_amt(position_reg));
        end
        else if (position_reg == b64id_pkg::LAST_POS)
        begin
            if ((code & b64id_pkg::TAIL_MASK) != 8'd0)
                bad_now = 1'b1;
            else
                accum_upd = accum_reg | 64'(code[5:2]);
        end
        else
        begin
            bad_now = 1'b1;
        end
    end

    assign token_ok = !(bad_reg || bad_now) && (position_reg == b64id_pkg::LAST_POS);

    always_comb
    begin
        position_next = position_reg;
        accum_next    = accum_reg;
        bad_next      = bad_reg;
        stored_next   = stored_reg;
        result_next   = result_reg;
        if (take)
        begin
            if (in_item.is_final)
            begin
                position_next = 4'd0;
                accum_next    = 64'd0;
                bad_next      = 1'b0;
                if (token_ok)
                    stored_next = accum_upd;
                result_next.ok    = token_ok;
                result_next.ident = token_ok ? accum_upd : stored_reg;
            end
            else
            begin
                accum_next = accum_upd;
                bad_next   = bad_reg || bad_now;
                if (position_reg < b64id_pkg::TOKEN_LEN)
                    position_next = position_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= 4'd0;
            accum_reg     <= 64'd0;
            bad_reg       <= 1'b0;
            stored_reg    <= 64'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            position_reg <= position_next;
            accum_reg    <= accum_next;
            bad_reg      <= bad_next;
            stored_reg   <= stored_next;
            if (advance)
                out_valid_reg <= in_valid && in_item.is_final;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

// ===== design/base64url_id_decoder_top.sv =====
// Top level of the base64url id decoder: input register, decode stage, checks.
// Depends on b64id_pkg, b64id_core and assert_macros.svh.
//
// Usage:
//   s_axis carries one ASCII character per request in tdata; tlast marks the
//   last character of an 11-character base64url token.
//   m_axis returns one request per token: tdata is the stored 64-bit id,
//   tuser is 1 when the token decoded and was stored, 0 on any error (the
//   previous id is returned unchanged).
//   Characters are taken one per clock. A request passes the input register
//   and then the decode stage's result register before its result is valid;
//   a stall on m_axis can hold it in either register.
//   Throughput: one character per cycle while m_axis is ready.
//   When m_axis stalls, the pending result holds, one more character can sit
//   in the input register, and s_axis_tready then drops.
//   Reset clears the token state and the stored id to zero and empties both
//   registers; the first character after reset starts a new token.
`default_nettype none
`include "assert_macros.svh"

module base64url_id_decoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  wire logic        s_axis_tlast,   // is_final
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [63:0] ident
    output logic             m_axis_tuser    // [0] ok
);

    logic               in_valid_reg;
    b64id_pkg::item_t   in_item_reg;
    logic               advance;
    logic               core_valid;
    b64id_pkg::result_t core_result;

    assign advance       = !core_valid || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready)
        begin
            in_item_reg.symbol   <= s_axis_tdata;
            in_item_reg.is_final <= s_axis_tlast;
        end
    end

    b64id_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (in_valid_reg),
        .in_item    (in_item_reg),
        .out_valid  (core_valid),
        .out_result (core_result)
    );

    assign m_axis_tvalid = core_valid;
    assign m_axis_tdata  = core_result.ident;
    assign m_axis_tuser  = core_result.ok;

    `B64_ASSERT_NEXT(a_hold_input, in_valid_reg && !advance, in_valid_reg)
    `B64_ASSERT_NEXT(a_result_from_final, !(in_valid_reg && in_item_reg.is_final),
                     !$rose(m_axis_tvalid))
    `B64_ASSERT_NEXT(a_no_result_midtoken,
                     advance && in_valid_reg && !in_item_reg.is_final, !m_axis_tvalid)

endmodule

`default_nettype wire

// ===== test/base64url_id_decoder_top_test.sv =====
// Testbench for base64url_id_decoder_top: streams base64url tokens and checks each
// per-token result against a cycle-free decoder model kept in the bench.
// Depends on b64id_pkg and the RTL under design/.
`default_nettype none

module base64url_id_decoder_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LATENCY_CYCLES = 2;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    // token decoder state, advanced on each accepted request
    logic [3:0]  tok_pos = '0;
    logic [63:0] tok_accum = '0;
    logic        tok_bad = 1'b0;
    logic [63:0] saved_ident = '0;

    b64id_pkg::result_t pending_results[$];
    int          failures = 0;
    int          quiet_cycles = 0;
    bit          no_idle = 1'b0;

    base64url_id_decoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] sextet_of(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return c - "A";
        if (c >= "a" && c <= "z")
            return c - "a" + b64id_pkg::CODE_LOWER_A;
        if (c >= "0" && c <= "9")
            return c - "0" + b64id_pkg::CODE_DIGIT0;
        if (c == "-")
            return b64id_pkg::CODE_DASH;
        if (c == "_")
            return b64id_pkg::CODE_USCORE;
        return b64id_pkg::INVALID_CODE;
    endfunction

    function automatic logic [7:0] char_of(input logic [5:0] v);
        if (v < 26)
            return "A" + v;
        if (v < b64id_pkg::CODE_DIGIT0)
            return "a" + (v - b64id_pkg::CODE_LOWER_A);
        if (v < b64id_pkg::CODE_DASH)
            return "0" + (v - b64id_pkg::CODE_DIGIT0);
        if (v == b64id_pkg::CODE_DASH)
            return "-";
        return "_";
    endfunction

    function automatic logic [7:0] rand_alpha();
        return char_of(6'($urandom_range(0, 63)));
    endfunction

    // last character with both pad bits clear
    function automatic logic [7:0] rand_tail();
        return char_of(6'($urandom_range(0, 15) << 2));
    endfunction

    function automatic void decode_char(input logic [7:0] sym, input logic fin);
        logic [7:0] v;
        logic       ok_now;
        int         sh;
        v = sextet_of(sym);
        if (tok_pos < b64id_pkg::LAST_POS)
        begin
            if ((v & b64id_pkg::BODY_MASK) != 0)
                tok_bad = 1'b1;
            else
            begin
                sh = 6 * (int'(b64id_pkg::LAST_POS) - int'(tok_pos)) - 2;
                tok_accum |= 64'(v[5:0]) << sh;
            end
        end
        else if (tok_pos == b64id_pkg::LAST_POS)
        begin
            if ((v & b64id_pkg::TAIL_MASK) != 0)
                tok_bad = 1'b1;
            else
                tok_accum |= 64'(v[5:2]);
        end
        else
            tok_bad = 1'b1;

        if (!fin)
        begin
            if (tok_pos < b64id_pkg::TOKEN_LEN)
                tok_pos = tok_pos + 4'd1;
        end
        else
        begin
            ok_now = !tok_bad && (tok_pos == b64id_pkg::LAST_POS);
            if (ok_now)
                saved_ident = tok_accum;
            pending_results.push_back('{ok: ok_now, ident: saved_ident});
            tok_pos = '0;
            tok_accum = '0;
            tok_bad = 1'b0;
        end
    endfunction

    // called right after an edge; returns at the edge that accepts the request
    task automatic send_char(input logic [7:0] sym, input logic fin);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tlast  <= fin;
        do @(posedge clk); while (!s_axis_tready);
        decode_char(sym, fin);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_good_token();
        for (int i = 0; i < 10; i++)
            send_char(rand_alpha(), 1'b0);
        send_char(rand_tail(), 1'b1);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_max_ident();
        send_text("__________8");
    endtask

    task automatic test_pad_bits();
        send_text("Az9-_aZ0AAB");
    endtask

    task automatic test_too_long();
        send_text("AAAAAAAAAAAA");
    endtask

    task automatic test_short_tokens();
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);
    endtask

    task automatic test_random_tokens(input int n_chars);
        int sent;
        int kind;
        int len;
        int bad_at;
        logic [7:0] c;
        sent = 0;
        while (sent < n_chars)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                send_good_token();
                sent += 11;
            end
            else if (kind < 82)
            begin
                // right length, one corrupted character or a random last one
                bad_at = $urandom_range(0, 12);
                for (int i = 0; i < 11; i++)
                begin
                    if (i == bad_at)
                        c = 8'($urandom_range(0, 255));
                    else if (i == 10)
                        c = rand_alpha();
                    else
                        c = rand_alpha();
                    send_char(c, i == 10);
                end
                sent += 11;
            end
            else if (kind < 95)
            begin
                len = $urandom_range(1, 14);
                for (int i = 0; i < len; i++)
                begin
                    c = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) : rand_alpha();
                    send_char(c, i == len - 1);
                end
                sent += len;
            end
            else
            begin
                send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                sent += 1;
            end
        end
    endtask

    task automatic test_drain_pause();
        repeat (3)
        begin
            send_good_token();
            drain_results();
        end
    endtask

    task automatic test_back_to_back(input int n_chars);
        no_idle = 1'b1;
        test_random_tokens(n_chars);
        no_idle = 1'b0;
    endtask

    initial
    begin : sink_ready
        int n;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            n = idle_len();
            if (n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        b64id_pkg::result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: ok %b ident %h", m_axis_tuser, m_axis_tdata);
                    failures++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_axis_tuser !== want.ok)
                    begin
                        $error("ok: expected %b, actual %b", want.ok, m_axis_tuser);
                        failures++;
                    end
                    if (m_axis_tdata !== want.ident)
                    begin
                        $error("ident: expected %h, actual %h", want.ident, m_axis_tdata);
                        failures++;
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        wait (rst_n === 1'b1);
        @(posedge clk);
        test_max_ident();
        test_pad_bits();
        test_too_long();
        test_short_tokens();
        test_random_tokens(800);
        test_drain_pause();
        test_back_to_back(250);
        test_random_tokens(670);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4 * LATENCY_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
